// ===== hw/rtl/afe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_pkg: shared constants for the Ackley function evaluator
// Fixed-point constants, widths and the cosine series divisors.
// ----------------------------------------------------------------------------
package afe_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 16;
  localparam int OBJ_W     = 32;
  localparam int FIT_W     = 25;

  localparam logic [31:0] ONE30     = 32'd1073741824;
  localparam logic [31:0] ONE24     = 32'd16777216;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] E_Q30     = 32'd2918732888;
  localparam logic [31:0] FIFTH_Q26 = 32'd13421773;

  // 20 + e in Q30.
  localparam logic [39:0] OBJ_BIAS  = 40'd24393569368;
  localparam logic [63:0] MS_LIM    = 64'd1 << (14 + 2 * FRAC_BITS);
  localparam int          SQ_SHIFT  = 48 - 2 * FRAC_BITS;

  localparam logic [3:0]  COS_TERMS = 4'd8;
  localparam logic [3:0]  EXP_TERMS = 4'd12;

  function automatic logic [7:0] cos_den(input logic [3:0] k);
    logic [7:0] d;
    case (k)
      4'd8:    d = 8'd240;
      4'd7:    d = 8'd182;
      4'd6:    d = 8'd132;
      4'd5:    d = 8'd90;
      4'd4:    d = 8'd56;
      4'd3:    d = 8'd30;
      4'd2:    d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/afe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_in_if: coordinate request channel
// Valid/ready channel that carries one coordinate and its last flag.
// ----------------------------------------------------------------------------
interface afe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [afe_pkg::COORD_W-1:0]   coordinate;
  logic                                 last_element;

  modport source (output valid, output coordinate, output last_element, input ready);
  modport sink   (input valid, input coordinate, input last_element, output ready);
endinterface

// ===== hw/rtl/afe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_out_if: result request channel
// Valid/ready channel that carries the objective and fitness of one point.
// ----------------------------------------------------------------------------
interface afe_out_if;
  logic                         valid;
  logic                         ready;
  logic [afe_pkg::OBJ_W-1:0]    objective_value;
  logic [afe_pkg::FIT_W-1:0]    fitness_value;

  modport source (output valid, output objective_value, output fitness_value, input ready);
  modport sink   (input valid, input objective_value, input fitness_value, output ready);
endinterface

// ===== hw/rtl/afe_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_mul: bit-serial unsigned multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module afe_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p,
  output logic           done
);

  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     mcand;
  logic [2*W-1:0]   prod;
  logic [W:0]       sum;

  assign sum = {1'b0, prod[2*W-1:W]} + (prod[0] ? {1'b0, mcand} : {(W+1){1'b0}});
  assign p   = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      prod  <= {{W{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[W-1:1]};
    end
  end

endmodule

// ===== hw/rtl/afe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the divisor must be nonzero.
// ----------------------------------------------------------------------------
module afe_div #(
  parameter int DW = 64,
  parameter int VW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(DW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [DW-1:0]    quo;
  logic [VW:0]      trial;
  logic             ge;

  assign trial    = {rem, quo[DW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/afe_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_sqrt: digit-serial integer square root
// Takes two radicand bits per cycle and yields one root bit, floor result.
// ----------------------------------------------------------------------------
module afe_sqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic [W/2-1:0] root,
  output logic           done
);

  localparam int RW    = W / 2 + 1;
  localparam int CNT_W = $clog2(W / 2);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     x;
  logic [RW-1:0]    rem;
  logic [W/2-1:0]   res;
  logic [RW+1:0]    shifted;
  logic [RW+1:0]    trial;
  logic             ge;

  assign shifted = {rem, x[W-1:W-2]};
  assign trial   = {1'b0, res, 2'b01};
  assign ge      = shifted >= trial;
  assign root    = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W / 2 - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      x   <= {x[W-3:0], 2'b00};
      rem <= ge ? RW'(shifted - trial) : RW'(shifted);
      res <= {res[W/2-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/ackley_function_evaluator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ackley_function_evaluator_core: fixed-point Ackley function evaluator
// Accumulates squares and cosines of coordinates and, on the last one or the
// MAX_DIMENSIONS-th, evaluates the Ackley value and its fitness with serial arithmetic units.
//
//   Channel   Dir  Payload                          Request moves
//   element   in   coordinate, last_element         one coordinate
//   result    out  objective_value, fitness_value   one evaluated point
//
// A coordinate takes eleven passes of the serial multiplier and eight of the
// serial divider, most of them for the cosine series.
// The last coordinate adds the final evaluation, dominated by the two 12-term
// exponential series on the same multiplier and divider.
// Reset clears the sums and the count; no clearing pass is needed.
// A pending result in the output register blocks input once the next is ready.
// ----------------------------------------------------------------------------
module ackley_function_evaluator_core #(
  parameter int MAX_DIMENSIONS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  afe_in_if.sink     element,
  afe_out_if.source  result
);

  localparam int CW = $clog2(MAX_DIMENSIONS + 1);

  typedef enum logic [18:0] {
    IDLE      = 19'b1 << 0,
    C_MUL_SQ  = 19'b1 << 1,
    C_MUL_R   = 19'b1 << 2,
    C_MUL_T   = 19'b1 << 3,
    C_MUL_P   = 19'b1 << 4,
    C_DIV_P   = 19'b1 << 5,
    C_ACC     = 19'b1 << 6,
    F_DIV_MS  = 19'b1 << 7,
    F_SQRT    = 19'b1 << 8,
    F_MUL_A   = 19'b1 << 9,
    X_MUL_V   = 19'b1 << 10,
    X_MUL_U   = 19'b1 << 11,
    X_MUL_H   = 19'b1 << 12,
    X_DIV_H   = 19'b1 << 13,
    X_MUL_M   = 19'b1 << 14,
    F_DIV_CM  = 19'b1 << 15,
    F_OBJ     = 19'b1 << 16,
    F_DIV_FIT = 19'b1 << 17,
    F_OUT     = 19'b1 << 18
  } state_t;

  state_t        state;
  logic          launched;
  logic [23:0]   x_q;
  logic          fin_q;
  logic [CW-1:0] cnt;
  logic [55:0]   sq_sum;
  logic [27:0]   cs_sum;
  logic [47:0]   sqp;
  logic [31:0]   theta;
  logic [31:0]   t;
  logic [31:0]   acc;
  logic [3:0]    kk;
  logic [63:0]   tmp;
  logic [6:0]    xk;
  logic [31:0]   w;
  logic          sel;
  logic [33:0]   e1;
  logic [33:0]   e2;
  logic [32:0]   den;
  logic [24:0]   fit_q;
  logic [31:0]   obj_q;
  logic          out_valid;
  logic [31:0]   out_obj;
  logic [24:0]   out_fit;

  logic          mul_start, div_start, sqrt_start, unit_done;
  logic          mul_done, div_done, sqrt_done;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [63:0]   div_dvd, div_quo;
  logic [33:0]   div_dvs;
  logic [31:0]   sqrt_root;

  logic [CW-1:0] cnt_inc;
  logic [23:0]   mag;
  logic [31:0]   ph;
  logic [1:0]    quad;
  logic [30:0]   r31;
  logic [16:0]   c17;
  logic [17:0]   cos_s;
  logic [28:0]   cs_add;
  logic [56:0]   sq_add;
  logic [27:0]   cs_mag;
  logic [35:0]   cm_sh;
  logic [63:0]   ms_c;
  logic [33:0]   mm;
  logic [7:0]    shamt;
  logic [33:0]   ex_res;
  logic [39:0]   e1x20;
  logic [39:0]   v40;
  logic [39:0]   v_pos;
  logic [39:0]   obj_r;
  logic [31:0]   obj32;

  assign element.ready          = (state == IDLE);
  assign result.valid           = out_valid;
  assign result.objective_value = out_obj;
  assign result.fitness_value   = out_fit;

  assign cnt_inc = cnt + 1'b1;
  assign mag     = x_q[23] ? 24'(-x_q) : x_q;
  assign ph      = 32'({x_q[afe_pkg::FRAC_BITS-1:0], {(32 - afe_pkg::FRAC_BITS){1'b0}}});
  assign quad    = ph[31:30];
  assign r31     = quad[0] ? (31'(afe_pkg::ONE30) - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
  assign c17     = 17'(({1'b0, acc} + 33'd8192) >> 14);
  assign cos_s   = (quad == 2'd1 || quad == 2'd2) ? 18'(-{1'b0, c17}) : {1'b0, c17};
  assign cs_add  = {cs_sum[27], cs_sum} + {{11{cos_s[17]}}, cos_s};
  assign sq_add  = {1'b0, sq_sum} + 57'(sqp);
  assign cs_mag  = cs_sum[27] ? 28'(-cs_sum) : cs_sum;
  assign cm_sh   = {div_quo[27:0], 8'b0};
  assign ms_c    = (div_quo > afe_pkg::MS_LIM) ? afe_pkg::MS_LIM : div_quo;
  assign mm      = mul_p[63:30];
  assign shamt   = {1'b0, xk} + 8'd1;
  assign ex_res  = (shamt >= 8'd63) ? 34'd0 : (mm >> shamt);
  assign e1x20   = ({6'b0, e1} << 4) + ({6'b0, e1} << 2);
  assign v40     = afe_pkg::OBJ_BIAS - e1x20 - {6'b0, e2};
  assign v_pos   = v40[39] ? 40'd0 : v40;
  assign obj_r   = (v_pos + 40'd32) >> 6;
  assign obj32   = (obj_r[39:32] != 8'd0) ? 32'hFFFF_FFFF : obj_r[31:0];

  assign mul_start  = !launched && (state inside {C_MUL_SQ, C_MUL_R, C_MUL_T, C_MUL_P,
                                                  F_MUL_A, X_MUL_V, X_MUL_U, X_MUL_H,
                                                  X_MUL_M});
  assign div_start  = !launched && (state inside {C_DIV_P, F_DIV_MS, X_DIV_H, F_DIV_CM,
                                                  F_DIV_FIT});
  assign sqrt_start = !launched && (state == F_SQRT);
  assign unit_done  = mul_done || div_done || sqrt_done;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      C_MUL_SQ: begin mul_a = 32'(mag);  mul_b = 32'(mag);            end
      C_MUL_R:  begin mul_a = 32'(r31);  mul_b = afe_pkg::PI_Q30;     end
      C_MUL_T:  begin mul_a = theta;     mul_b = theta;               end
      C_MUL_P:  begin mul_a = t;         mul_b = acc;                 end
      F_MUL_A:  begin mul_a = theta;     mul_b = afe_pkg::FIFTH_Q26;  end
      X_MUL_V:  begin mul_a = w;         mul_b = afe_pkg::LOG2E_Q30;  end
      X_MUL_U:  begin mul_a = theta;     mul_b = afe_pkg::LN2_Q30;    end
      X_MUL_H:  begin mul_a = acc;       mul_b = t;                   end
      X_MUL_M:  begin mul_a = acc;       mul_b = afe_pkg::E_Q30;      end
      default:  begin mul_a = '0;        mul_b = '0;                  end
    endcase
  end

  always_comb begin
    div_dvd = '0;
    div_dvs = 34'd1;
    case (state)
      C_DIV_P:   begin div_dvd = tmp;               div_dvs = 34'(afe_pkg::cos_den(kk)); end
      F_DIV_MS:  begin div_dvd = {8'b0, sq_sum};    div_dvs = 34'(cnt);                  end
      X_DIV_H:   begin div_dvd = tmp;               div_dvs = 34'(kk);                   end
      F_DIV_CM:  begin div_dvd = 64'(cs_mag);       div_dvs = 34'(cnt);                  end
      F_DIV_FIT: begin
        div_dvd = (64'd1 << 48) + 64'(den[32:1]);
        div_dvs = 34'(den);
      end
      default:   begin div_dvd = '0;                div_dvs = 34'd1;                     end
    endcase
  end

  afe_mul #(.W(32)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .p(mul_p), .done(mul_done)
  );

  afe_div #(.DW(64), .VW(34)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .quotient(div_quo), .done(div_done)
  );

  afe_sqrt #(.W(64)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(tmp),
    .root(sqrt_root), .done(sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      sq_sum    <= '0;
      cs_sum    <= '0;
    end else begin
      if (unit_done) begin
        launched <= 1'b0;
      end else if (mul_start || div_start || sqrt_start) begin
        launched <= 1'b1;
      end
      if (state == F_OUT && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (element.valid) begin
            x_q   <= element.coordinate;
            cnt   <= cnt_inc;
            fin_q <= element.last_element || (cnt_inc == CW'(MAX_DIMENSIONS));
            state <= C_MUL_SQ;
          end
        end
        C_MUL_SQ: begin
          if (unit_done) begin
            sqp   <= mul_p[47:0];
            state <= C_MUL_R;
          end
        end
        C_MUL_R: begin
          if (unit_done) begin
            theta <= mul_p[62:31];
            acc   <= afe_pkg::ONE30;
            kk    <= afe_pkg::COS_TERMS;
            state <= C_MUL_T;
          end
        end
        C_MUL_T: begin
          if (unit_done) begin
            t     <= mul_p[61:30];
            state <= C_MUL_P;
          end
        end
        C_MUL_P: begin
          if (unit_done) begin
            tmp   <= {30'b0, mul_p[63:30]};
            state <= C_DIV_P;
          end
        end
        C_DIV_P: begin
          if (unit_done) begin
            acc <= (div_quo >= 64'(afe_pkg::ONE30)) ? 32'd0
                                                    : afe_pkg::ONE30 - div_quo[31:0];
            kk  <= kk - 1'b1;
            state <= (kk == 4'd1) ? C_ACC : C_MUL_P;
          end
        end
        C_ACC: begin
          sq_sum <= sq_add[56] ? {56{1'b1}} : sq_add[55:0];
          if (cs_add[28] != cs_add[27]) begin
            cs_sum <= cs_add[28] ? {1'b1, 27'b0} : {1'b0, {27{1'b1}}};
          end else begin
            cs_sum <= cs_add[27:0];
          end
          state <= fin_q ? F_DIV_MS : IDLE;
        end
        F_DIV_MS: begin
          if (unit_done) begin
            tmp   <= ms_c << afe_pkg::SQ_SHIFT;
            state <= F_SQRT;
          end
        end
        F_SQRT: begin
          if (unit_done) begin
            theta <= sqrt_root;
            state <= F_MUL_A;
          end
        end
        F_MUL_A: begin
          if (unit_done) begin
            w     <= afe_pkg::ONE24 + 32'((mul_p + (64'd1 << 25)) >> 26);
            sel   <= 1'b0;
            state <= X_MUL_V;
          end
        end
        X_MUL_V: begin
          if (unit_done) begin
            xk    <= mul_p[60:54];
            theta <= 32'(31'(afe_pkg::ONE30) - {1'b0, mul_p[53:24]});
            state <= X_MUL_U;
          end
        end
        X_MUL_U: begin
          if (unit_done) begin
            t     <= mul_p[61:30];
            acc   <= afe_pkg::ONE30;
            kk    <= afe_pkg::EXP_TERMS;
            state <= X_MUL_H;
          end
        end
        X_MUL_H: begin
          if (unit_done) begin
            tmp   <= {30'b0, mul_p[63:30]};
            state <= X_DIV_H;
          end
        end
        X_DIV_H: begin
          if (unit_done) begin
            acc   <= afe_pkg::ONE30 + div_quo[31:0];
            kk    <= kk - 1'b1;
            state <= (kk == 4'd1) ? X_MUL_M : X_MUL_H;
          end
        end
        X_MUL_M: begin
          if (unit_done) begin
            if (!sel) begin
              e1    <= ex_res;
              state <= F_DIV_CM;
            end else begin
              e2    <= ex_res;
              state <= F_OBJ;
            end
          end
        end
        F_DIV_CM: begin
          if (unit_done) begin
            w     <= cs_sum[27] ? 32'(37'(afe_pkg::ONE24) + 37'(cm_sh))
                                : 32'(37'(afe_pkg::ONE24) - 37'(cm_sh));
            sel   <= 1'b1;
            state <= X_MUL_V;
          end
        end
        F_OBJ: begin
          obj_q <= obj32;
          den   <= {1'b0, obj32} + 33'(afe_pkg::ONE24);
          state <= F_DIV_FIT;
        end
        F_DIV_FIT: begin
          if (unit_done) begin
            fit_q <= div_quo[24:0];
            state <= F_OUT;
          end
        end
        F_OUT: begin
          if (!out_valid || result.ready) begin
            out_obj   <= obj_q;
            out_fit   <= fit_q;
            cnt       <= '0;
            sq_sum    <= '0;
            cs_sum    <= '0;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/afe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_checker: port-level checks for the Ackley function evaluator
// Watches the request channels of the top level over time.
// ----------------------------------------------------------------------------
module afe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] objective_value,
  input logic [24:0] fitness_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(objective_value) && $stable(fitness_value))
    else $error("result payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("coordinate accepted while previous one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a point in work");

  a_fitness_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fitness_value <= 25'd16777216)
    else $error("fitness above one");

endmodule

bind ackley_function_evaluator_core afe_checker u_afe_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(element.valid),
  .in_ready(element.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .objective_value(result.objective_value),
  .fitness_value(result.fitness_value)
);

// ===== tb/sv/ackley_function_evaluator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ackley_function_evaluator_core_tb: self-checking bench for the Ackley core
// Streams points of signed coordinates through the element channel with
// bursty traffic and compares every objective and fitness result against a
// bit-accurate fixed-point model of the evaluator kept in the bench.
// ----------------------------------------------------------------------------
module ackley_function_evaluator_core_tb;

  localparam int MAX_DIM = 1024;
  localparam int STALL_LIMIT = 60000;
  localparam int LONG_HOLD = 15000;
  localparam int DRAIN_CYCLES = 5000;
  localparam logic [63:0] Q30 = 64'(afe_pkg::ONE30);
  localparam logic [63:0] Q24 = 64'(afe_pkg::ONE24);
  localparam logic [63:0] SQ_SAT = (64'd1 << 56) - 64'd1;
  localparam longint COS_HI = 64'sd134217727;
  localparam longint COS_LO = -64'sd134217728;

  typedef struct packed {
    logic [afe_pkg::OBJ_W-1:0] objective;
    logic [afe_pkg::FIT_W-1:0] fitness;
  } point_result_t;

  logic clk;
  logic rst;

  afe_in_if  element();
  afe_out_if result();

  ackley_function_evaluator_core #(.MAX_DIMENSIONS(MAX_DIM)) dut (
    .clk    (clk),
    .rst    (rst),
    .element(element),
    .result (result)
  );

  logic [63:0]   sq_acc;
  longint        cos_acc;
  int            coord_cnt;
  point_result_t expected_points[$];
  int            error_count;
  int            idle_cycles;
  int            burst_left;
  int            hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint cosine_q16(input logic [15:0] frac);
    logic [31:0] phase;
    logic [1:0]  quad;
    logic [63:0] r, theta, t, acc, term, c;
    phase = {frac, 16'h0000};
    quad = phase[31:30];
    r = {34'd0, phase[29:0]};
    if (quad[0]) begin
      r = Q30 - r;
    end
    theta = (r * 64'(afe_pkg::PI_Q30)) >> 31;
    t = (theta * theta) >> 30;
    acc = Q30;
    for (int k = 8; k >= 1; k--) begin
      term = ((t * acc) >> 30) / 64'((2 * k - 1) * (2 * k));
      acc = (term >= Q30) ? 64'd0 : Q30 - term;
    end
    c = (acc + 64'd8192) >> 14;
    return (quad == 2'd1 || quad == 2'd2) ? -longint'(c) : longint'(c);
  endfunction

  function automatic logic [63:0] exp_one_minus(input logic [63:0] w);
    logic [63:0] v, k, g, u, acc, m, s;
    v = (w * 64'(afe_pkg::LOG2E_Q30)) >> 24;
    k = v >> 30;
    g = Q30 - (v & (Q30 - 64'd1));
    u = (g * 64'(afe_pkg::LN2_Q30)) >> 30;
    acc = Q30;
    for (int i = 12; i >= 1; i--) begin
      acc = Q30 + ((acc * u) >> 30) / 64'(i);
    end
    m = (acc * 64'(afe_pkg::E_Q30)) >> 30;
    s = k + 64'd1;
    return (s >= 64'd63) ? 64'd0 : (m >> s);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > x) begin
      b = b >> 2;
    end
    while (b != 64'd0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic accumulate_coordinate(input logic signed [afe_pkg::COORD_W-1:0] coord,
                                       input logic last);
    longint      xv, cm, v;
    logic [63:0] mag, n, ms, root, a, e1, e2, obj, den;
    point_result_t pr;
    xv = longint'(coord);
    mag = 64'((xv < 0) ? -xv : xv);
    sq_acc = sq_acc + mag * mag;
    if (sq_acc > SQ_SAT) begin
      sq_acc = SQ_SAT;
    end
    cos_acc = cos_acc + cosine_q16(coord[15:0]);
    if (cos_acc > COS_HI) cos_acc = COS_HI;
    if (cos_acc < COS_LO) cos_acc = COS_LO;
    coord_cnt++;
    if (!last && coord_cnt < MAX_DIM) begin
      return;
    end
    n = 64'(coord_cnt);
    ms = sq_acc / n;
    if (ms > afe_pkg::MS_LIM) begin
      ms = afe_pkg::MS_LIM;
    end
    root = floor_sqrt(ms << afe_pkg::SQ_SHIFT);
    a = (root * 64'(afe_pkg::FIFTH_Q26) + (64'd1 << 25)) >> 26;
    e1 = exp_one_minus(Q24 + a);
    cm = cos_acc / longint'(n);
    e2 = exp_one_minus(64'(longint'(Q24) - cm * 256));
    v = longint'(20 * Q30 + 64'(afe_pkg::E_Q30)) - longint'(20 * e1) - longint'(e2);
    if (v < 0) begin
      v = 0;
    end
    obj = (64'(v) + 64'd32) >> 6;
    if (obj > 64'hFFFF_FFFF) begin
      obj = 64'hFFFF_FFFF;
    end
    den = obj + Q24;
    pr.objective = obj[afe_pkg::OBJ_W-1:0];
    pr.fitness = 25'((((64'd1 << 48) + den / 64'd2) / den));
    expected_points.push_back(pr);
    sq_acc = 64'd0;
    cos_acc = 0;
    coord_cnt = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_coordinate(input logic signed [afe_pkg::COORD_W-1:0] coord,
                                 input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        element.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    element.valid <= 1'b1;
    element.coordinate <= coord;
    element.last_element <= last;
    do begin
      @(posedge clk);
    end while (!(element.valid && element.ready));
    accumulate_coordinate(coord, last);
  endtask

  task automatic send_point(input int len, input int kind);
    logic signed [afe_pkg::COORD_W-1:0] c;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: c = 24'($urandom);
        1: c = $signed(24'($urandom_range(0, 32'h7FFFF))) - 24'sh40000;
        default: c = {8'($urandom_range(0, 1) ? 8'hFF : 8'h00), 16'($urandom)};
      endcase
      send_coordinate(c, i == len - 1);
    end
  endtask

  task automatic test_origin();
    send_coordinate(24'sd0, 1'b1);
    send_coordinate(24'sd0, 1'b0);
    send_coordinate(24'sd0, 1'b0);
    send_coordinate(24'sd0, 1'b1);
  endtask

  task automatic test_extremes();
    send_coordinate(24'sh7FFFFF, 1'b1);
    send_coordinate(-24'sh800000, 1'b1);
    send_coordinate(24'sh7FFFFF, 1'b0);
    send_coordinate(-24'sh800000, 1'b1);
    send_coordinate(24'sh010000, 1'b0);
    send_coordinate(-24'sh010000, 1'b1);
  endtask

  task automatic test_cosine_phases();
    send_coordinate(24'sh004000, 1'b0);
    send_coordinate(24'sh008000, 1'b0);
    send_coordinate(24'sh00C000, 1'b0);
    send_coordinate(24'sh000001, 1'b0);
    send_coordinate(24'sh00FFFF, 1'b1);
    send_coordinate(-24'sh008000, 1'b0);
    send_coordinate(24'sh5A3FFF, 1'b1);
  endtask

  // The full-length point uses the largest magnitude so the square sum saturates.
  task automatic test_dimension_limit();
    for (int i = 0; i < MAX_DIM; i++) begin
      send_coordinate(-24'sh800000, 1'b0);
    end
    send_coordinate(24'sh000123, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_request++;
    for (int i = 0; i < 6; i++) begin
      send_point(1, 1);
    end
  endtask

  task automatic test_random(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      send_point(len, $urandom_range(0, 2));
      sent += len;
    end
  endtask

  initial begin
    int mode;
    int left;
    int hold_left;
    int hold_seen;
    result.ready = 1'b0;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_seen = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        result.ready <= 1'b0;
        hold_left--;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(200, 3000);
        end
        left--;
        case (mode)
          0: result.ready <= 1'b1;
          1: result.ready <= ($urandom_range(0, 1) == 1);
          default: result.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    point_result_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", {32'd0, result.objective_value}, 64'd0);
      end else begin
        want = expected_points.pop_front();
        if (result.objective_value !== want.objective) begin
          report_mismatch("objective_value", result.objective_value, want.objective);
        end
        if (result.fitness_value !== want.fitness) begin
          report_mismatch("fitness_value", result.fitness_value, want.fitness);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (element.valid && element.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    element.valid = 1'b0;
    element.coordinate = '0;
    element.last_element = 1'b0;
    sq_acc = 64'd0;
    cos_acc = 0;
    coord_cnt = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_origin();
    test_extremes();
    test_cosine_phases();
    test_dimension_limit();
    test_backpressure();
    test_random(840);
    element.valid <= 1'b0;
    while (expected_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/afe_pkg.sv
hw/rtl/afe_in_if.sv
hw/rtl/afe_out_if.sv
hw/rtl/afe_mul.sv
hw/rtl/afe_div.sv
hw/rtl/afe_sqrt.sv
hw/rtl/ackley_function_evaluator_core.sv
hw/rtl/afe_checker.sv
tb/sv/ackley_function_evaluator_core_tb.sv
